### design/rfid_tag_mutual_auth_macros.svh
// Assertion macros shared by the tag authentication RTL.
// Include by bare file name; no other dependencies.
`ifndef RFID_TAG_MUTUAL_AUTH_MACROS_SVH
`define RFID_TAG_MUTUAL_AUTH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RFIDTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfidta: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RFIDTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfidta: next-cycle check failed");

`endif

### design/rfidta_pkg.sv
// Shared types and constants for the tag authentication block.
// No dependencies.
`default_nettype none

package rfidta_pkg;

    localparam int unsigned DIGIT_BUFFER_DEF = 40;
    localparam int unsigned NUM_HASH_ARGS    = 4;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    typedef enum logic [1:0] {
        OP_CHALLENGE = 2'd0,
        OP_CONFIRM   = 2'd1,
        OP_RELOAD    = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CHALLENGE = 2'd0,
        KIND_VERDICT   = 2'd1,
        KIND_RELOAD    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_TAG_CODE = 2'd0,
        REG_INIT_SEQ = 2'd1,
        REG_INIT_KEY = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_LOAD,
        HS_DIGIT,
        HS_DONE
    } hash_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } top_state_t;

    typedef struct packed {
        logic                               start;
        logic [NUM_HASH_ARGS-1:0][31:0]     vals;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] sum;
    } hash_rsp_t;

endpackage

`default_nettype wire

### design/rfidta_req_if.sv
// Request channel interface: op and operands with valid/ready.
// No dependencies.
`default_nettype none

interface rfidta_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] reader_nonce;
    logic [30:0]        fresh_random;
    logic signed [31:0] reader_proof;

    modport source (output valid, op, reader_nonce, fresh_random, reader_proof,
                    input ready);
    modport sink   (input valid, op, reader_nonce, fresh_random, reader_proof,
                    output ready);
endinterface

`default_nettype wire

### design/rfidta_rsp_if.sv
// Response channel interface: reply fields with valid/ready.
// No dependencies.
`default_nettype none

interface rfidta_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         reply_kind;
    logic signed [31:0] pseudonym;
    logic signed [31:0] masked_index;
    logic signed [31:0] tag_proof;
    logic               auth_ok;

    modport source (output valid, reply_kind, pseudonym, masked_index, tag_proof,
                    auth_ok, input ready);
    modport sink   (input valid, reply_kind, pseudonym, masked_index, tag_proof,
                    auth_ok, output ready);
endinterface

`default_nettype wire

### design/rfidta_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// No dependencies.
`default_nettype none

interface rfidta_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [31:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### design/rfidta_hash.sv
// Iterative digit hash: one decimal digit per cycle through a shared
// reciprocal multiplier. Depends on rfidta_pkg and the assertion macros.
`default_nettype none
`include "rfid_tag_mutual_auth_macros.svh"

module rfidta_hash import rfidta_pkg::*; #(
    parameter int unsigned DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire hash_req_t req,
    output hash_rsp_t      rsp
);

    localparam int unsigned CNT_W = $clog2(DIGIT_BUFFER + 1);
    localparam int unsigned ARG_W = $clog2(NUM_HASH_ARGS);

    hash_state_t state_reg, state_next;

    logic [NUM_HASH_ARGS-1:0][31:0] vals_reg;
    logic [ARG_W-1:0]               k_reg;
    logic [31:0]                    mag_reg;
    logic                           neg_reg;
    logic [31:0]                    sum_reg;
    logic [CNT_W-1:0]               cnt_reg;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem_wide;
    logic [3:0]  dig;
    logic [31:0] addend;
    logic [31:0] sum_step;
    logic [31:0] cur_val;
    logic [31:0] mag_load;
    logic        last_arg;
    logic        stop;

    always_comb
    begin
        prod     = {32'd0, mag_reg} * {32'd0, RECIP10};
        quot     = {3'd0, prod[63:RECIP10_SHIFT]};
        rem_wide = mag_reg - ((quot << 3) + (quot << 1));
        dig      = rem_wide[3:0];
        addend   = neg_reg ? (32'd0 - {28'd0, dig}) : {28'd0, dig};
        sum_step = {sum_reg[30:0], 1'b0} + addend;
        cur_val  = vals_reg[k_reg];
        mag_load = cur_val[31] ? (32'd0 - cur_val) : cur_val;
        last_arg = (k_reg == ARG_W'(NUM_HASH_ARGS - 1));
        // digit minus one ends the string; buffer limit is a hard stop
        stop     = (neg_reg && (dig == 4'd1)) || (cnt_reg >= CNT_W'(DIGIT_BUFFER));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            HS_IDLE:
            begin
                if (req.start)
                    state_next = HS_LOAD;
            end
            HS_LOAD:
                state_next = HS_DIGIT;
            HS_DIGIT:
            begin
                if (mag_reg == 32'd0)
                    state_next = last_arg ? HS_DONE : HS_LOAD;
                else if (stop)
                    state_next = HS_DONE;
            end
            HS_DONE:
                state_next = HS_IDLE;
            default:
                state_next = HS_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == HS_DONE);
        rsp.sum  = sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                HS_IDLE:
                begin
                    if (req.start)
                    begin
                        k_reg   <= '0;
                        cnt_reg <= '0;
                    end
                end
                HS_DIGIT:
                begin
                    if (mag_reg == 32'd0)
                    begin
                        if (!last_arg)
                            k_reg <= k_reg + 1'b1;
                    end
                    else if (!stop)
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            HS_IDLE:
            begin
                if (req.start)
                begin
                    vals_reg <= req.vals;
                    sum_reg  <= '0;
                end
            end
            HS_LOAD:
            begin
                mag_reg <= mag_load;
                neg_reg <= cur_val[31];
            end
            HS_DIGIT:
            begin
                if ((mag_reg != 32'd0) && !stop)
                begin
                    sum_reg <= sum_step;
                    mag_reg <= quot;
                end
            end
            default:
            begin
            end
        endcase
    end

    `RFIDTA_ASSERT_IMP(a_start_idle, clk, rst_n, req.start, state_reg == HS_IDLE)
    `RFIDTA_ASSERT_NXT(a_done_pulse, clk, rst_n, rsp.done, !rsp.done)
    `RFIDTA_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DIGIT_BUFFER))

endmodule

`default_nettype wire

### design/rfid_tag_mutual_auth.sv
// Top level of the tag authentication block: config registers, tag state,
// op sequencer and output register. Uses rfidta_pkg, the channel interfaces,
// rfidta_hash and the assertion macros.
//
//  channel | modport | payload                                         | moves
//  req     | sink    | op, reader_nonce, fresh_random, reader_proof    | one op
//  rsp     | source  | reply_kind, pseudonym, masked_index, tag_proof,  | one reply
//          |         | auth_ok                                         |
//  cfg     | sink    | addr, data                                      | one write
//
// Each hash folds d decimal digits (d <= 40; fewer when a minus-one digit ends
// the string). An op runs its hashes between accepts: one for reload, two for
// challenge, one or three for confirm. Op 3 is accepted and dropped.
// req.ready is high only while idle; a finished reply waits in the output
// register while the next op is taken.
// Reset clears all tag state to zero; cfg.ready is always high.
`default_nettype none
`include "rfid_tag_mutual_auth_macros.svh"

module rfid_tag_mutual_auth import rfidta_pkg::*; #(
    parameter int unsigned DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rfidta_req_if.sink   req,
    rfidta_rsp_if.source rsp,
    rfidta_cfg_if.sink   cfg
);

    top_state_t state_reg, state_next;

    op_t         op_reg;
    logic [1:0]  step_reg;
    logic [31:0] r1_reg;
    logic [31:0] proof_reg;

    logic [30:0] code_reg;
    logic [31:0] init_seq_reg;
    logic [31:0] init_key_reg;

    logic [31:0] seq_reg;
    logic [31:0] key_reg;
    logic [31:0] ps_reg;
    logic [30:0] saved_reg;

    logic [31:0] m1_work_reg;
    logic [31:0] m2_work_reg;
    logic        ok_work_reg;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [31:0] out_ps_reg;
    logic [31:0] out_m1_reg;
    logic [31:0] out_m2_reg;
    logic        out_ok_reg;

    hash_req_t hreq;
    hash_rsp_t hrsp;

    logic        in_fire;
    logic        out_load;
    logic        last_hash;
    logic        proof_match;
    logic [31:0] code_ext;
    logic [31:0] saved_ext;
    logic [31:0] seq_inc;

    rfidta_hash #(
        .DIGIT_BUFFER(DIGIT_BUFFER)
    ) u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (hreq),
        .rsp  (hrsp)
    );

    assign code_ext    = {1'b0, code_reg};
    assign saved_ext   = {1'b0, saved_reg};
    assign seq_inc     = seq_reg + 32'd1;
    assign proof_match = (hrsp.sum == proof_reg);
    assign in_fire     = req.valid && req.ready;
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    // which hash result finishes the op
    always_comb
    begin
        case (op_reg)
            OP_CHALLENGE: last_hash = (step_reg == 2'd1);
            OP_CONFIRM:   last_hash = (step_reg == 2'd2) ||
                                      ((step_reg == 2'd0) && !proof_match);
            default:      last_hash = 1'b1;
        endcase
    end

    // hash operands per op and step
    always_comb
    begin
        hreq.start = (state_reg == ST_ISSUE);
        hreq.vals  = {32'd0, 32'd0, seq_reg, code_ext};
        case (op_reg)
            OP_CHALLENGE:
            begin
                if (step_reg == 2'd1)
                    hreq.vals = {key_reg, saved_ext, r1_reg, code_ext};
            end
            OP_CONFIRM:
            begin
                if (step_reg == 2'd0)
                    hreq.vals = {key_reg, seq_inc, saved_ext, code_ext};
                else if (step_reg == 2'd1)
                    hreq.vals = {32'd0, 32'd0, saved_ext, key_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op_t'(req.op) != OP_NONE))
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (hrsp.done)
                    state_next = last_hash ? ST_EMIT : ST_ISSUE;
            end
            ST_EMIT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready        = (state_reg == ST_IDLE);
        cfg.ready        = 1'b1;
        rsp.valid        = out_valid_reg;
        rsp.reply_kind   = out_kind_reg;
        rsp.pseudonym    = out_ps_reg;
        rsp.masked_index = out_m1_reg;
        rsp.tag_proof    = out_m2_reg;
        rsp.auth_ok      = out_ok_reg;
    end

    // control and architectural tag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
            init_seq_reg  <= '0;
            init_key_reg  <= '0;
            seq_reg       <= '0;
            key_reg       <= '0;
            ps_reg        <= '0;
            saved_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (reg_idx_t'(cfg.addr))
                    REG_TAG_CODE: code_reg     <= cfg.data[30:0];
                    REG_INIT_SEQ: init_seq_reg <= cfg.data;
                    REG_INIT_KEY: init_key_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_fire)
                    begin
                        case (op_t'(req.op))
                            OP_CHALLENGE: saved_reg <= req.fresh_random;
                            OP_RELOAD:
                            begin
                                seq_reg <= init_seq_reg;
                                key_reg <= init_key_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_WAIT:
                begin
                    if (hrsp.done)
                    begin
                        step_reg <= step_reg + 2'd1;
                        case (op_reg)
                            OP_CONFIRM:
                            begin
                                if ((step_reg == 2'd0) && proof_match)
                                    seq_reg <= seq_inc;
                                else if (step_reg == 2'd1)
                                    key_reg <= hrsp.sum;
                                else if (step_reg == 2'd2)
                                    ps_reg <= hrsp.sum;
                            end
                            OP_RELOAD:
                                ps_reg <= hrsp.sum;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // op operands, working results and the output register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= op_t'(req.op);
            r1_reg      <= req.reader_nonce;
            proof_reg   <= req.reader_proof;
            m1_work_reg <= '0;
            m2_work_reg <= '0;
            ok_work_reg <= 1'b0;
        end

        if ((state_reg == ST_WAIT) && hrsp.done)
        begin
            case (op_reg)
                OP_CHALLENGE:
                begin
                    if (step_reg == 2'd0)
                        m1_work_reg <= hrsp.sum ^ saved_ext;
                    else
                        m2_work_reg <= hrsp.sum;
                end
                OP_CONFIRM:
                begin
                    if ((step_reg == 2'd0) && proof_match)
                        ok_work_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (out_load)
        begin
            out_ps_reg <= '0;
            out_m1_reg <= m1_work_reg;
            out_m2_reg <= m2_work_reg;
            out_ok_reg <= ok_work_reg;
            case (op_reg)
                OP_CHALLENGE:
                begin
                    out_kind_reg <= KIND_CHALLENGE;
                    out_ps_reg   <= ps_reg;
                end
                OP_CONFIRM:   out_kind_reg <= KIND_VERDICT;
                default:      out_kind_reg <= KIND_RELOAD;
            endcase
        end
    end

    `RFIDTA_ASSERT_NXT(a_op_starts, clk, rst_n, in_fire && (op_t'(req.op) != OP_NONE), state_reg == ST_ISSUE)
    `RFIDTA_ASSERT_IMP(a_done_in_wait, clk, rst_n, hrsp.done, state_reg == ST_WAIT)
    `RFIDTA_ASSERT_IMP(a_ok_verdict, clk, rst_n, out_valid_reg && out_ok_reg, out_kind_reg == KIND_VERDICT)
    `RFIDTA_ASSERT_NXT(a_emit_fills, clk, rst_n, out_load, out_valid_reg)

endmodule

`default_nettype wire
